### src/mexp_pkg.sv
// Shared constants, codes and control types for the modular exponentiation block.
package mexp_pkg;

    localparam int OPERAND_WIDTH_DEFAULT = 31;

    typedef enum logic [1:0] {
        OP_REDUCE  = 2'd0,
        OP_MUL_ACC = 2'd1,
        OP_SQUARE  = 2'd2
    } mexp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE_WAIT,
        ST_BIT,
        ST_MUL_WAIT,
        ST_SQ_WAIT,
        ST_FINISH
    } mexp_state_t;

    typedef struct packed {
        logic     load;
        logic     start;
        mexp_op_t op;
        logic     shift_expo;
        logic     write_out;
    } mexp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic expo_zero;
        logic expo_bit0;
        logic expo_last;
        logic unit_busy;
        logic unit_done;
        logic out_free;
    } mexp_status_t;

endpackage

### src/mexp_mulmod.sv
// Bit-serial interleaved multiply-and-reduce unit, one multiplier bit per cycle; reduce mode gives y mod m.
module mexp_mulmod #(
    parameter int W = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         reduce_mode,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] r
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]  r_reg;
    logic [W-1:0]  y_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;

    logic          bit_in;
    logic [W-1:0]  addend;
    logic [W+1:0]  t;
    logic [W+2:0]  d1;
    logic [W+2:0]  d2;
    logic [W-1:0]  r_step;

    always_comb
    begin
        bit_in = y_reg[W-1];
        if (reduce_mode)
        begin
            addend = {{(W-1){1'b0}}, bit_in};
        end
        else
        begin
            addend = bit_in ? x : '0;
        end
        // r < m and addend < m (or one bit), so t < 3m
        t  = {1'b0, r_reg, 1'b0} + {2'b00, addend};
        d1 = {1'b0, t} - {3'b000, m};
        d2 = {1'b0, t} - {2'b00, m, 1'b0};
        priority if (!d2[W+2])
        begin
            r_step = d2[W-1:0];
        end
        else if (!d1[W+2])
        begin
            r_step = d1[W-1:0];
        end
        else
        begin
            r_step = t[W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            y_reg <= y;
        end
        else if (busy_reg)
        begin
            r_reg <= r_step;
            y_reg <= {y_reg[W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign r    = r_reg;

endmodule

### src/mexp_datapath.sv
// Operand, accumulator and output registers around the shared multiply-reduce unit.
module mexp_datapath #(
    parameter int W = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mexp_pkg::mexp_cmd_t    cmd,
    output mexp_pkg::mexp_status_t stat,
    input  logic [W-1:0]           base_value,
    input  logic [W-1:0]           exponent_value,
    input  logic [W-1:0]           modulus_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [W-1:0]           power_result,
    output logic                   zero_modulus_error
);

    logic [W-1:0]        base_reg;
    logic [W-1:0]        expo_reg;
    logic [W-1:0]        mod_reg;
    logic [W-1:0]        acc_reg;
    logic [W-1:0]        result_reg;
    logic                err_reg;
    logic                out_valid_reg;
    mexp_pkg::mexp_op_t  op_reg;

    logic                unit_busy;
    logic                unit_done;
    logic [W-1:0]        unit_r;
    logic [W-1:0]        unit_y;
    logic                mod_zero;

    assign mod_zero = (mod_reg == '0);
    assign unit_y   = (cmd.op == mexp_pkg::OP_MUL_ACC) ? acc_reg : base_reg;

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.start),
        .reduce_mode (op_reg == mexp_pkg::OP_REDUCE),
        .x           (base_reg),
        .y           (unit_y),
        .m           (mod_reg),
        .busy        (unit_busy),
        .done        (unit_done),
        .r           (unit_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_value;
            expo_reg <= exponent_value;
            mod_reg  <= modulus_value;
            acc_reg  <= {{(W-1){1'b0}}, 1'b1};
        end
        else
        begin
            if (cmd.shift_expo)
            begin
                expo_reg <= {1'b0, expo_reg[W-1:1]};
            end
            if (unit_done)
            begin
                unique case (op_reg)
                    mexp_pkg::OP_MUL_ACC: acc_reg  <= unit_r;
                    mexp_pkg::OP_REDUCE,
                    mexp_pkg::OP_SQUARE:  base_reg <= unit_r;
                    default:              acc_reg  <= acc_reg;
                endcase
            end
        end
        if (cmd.start)
        begin
            op_reg <= cmd.op;
        end
        if (cmd.write_out)
        begin
            result_reg <= mod_zero ? '0 : acc_reg;
            err_reg    <= mod_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.write_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.mod_zero  = mod_zero;
        stat.expo_zero = (expo_reg == '0);
        stat.expo_bit0 = expo_reg[0];
        stat.expo_last = (expo_reg[W-1:1] == '0);
        stat.unit_busy = unit_busy;
        stat.unit_done = unit_done;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign power_result       = result_reg;
    assign zero_modulus_error = err_reg;

endmodule

### src/mexp_ctrl.sv
// Sequencer for the square-and-multiply exponent scan.
module mexp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mexp_pkg::mexp_status_t stat,
    output mexp_pkg::mexp_cmd_t    cmd
);

    mexp_pkg::mexp_state_t state_reg;
    mexp_pkg::mexp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (stat.mod_zero || stat.expo_zero)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = mexp_pkg::ST_REDUCE_WAIT;
                end
            end
            mexp_pkg::ST_REDUCE_WAIT:
            begin
                if (stat.unit_done)
                begin
                    state_next = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_BIT:
            begin
                if (stat.expo_bit0)
                begin
                    state_next = mexp_pkg::ST_MUL_WAIT;
                end
                else
                begin
                    state_next = mexp_pkg::ST_SQ_WAIT;
                end
            end
            mexp_pkg::ST_MUL_WAIT:
            begin
                if (stat.unit_done)
                begin
                    state_next = stat.expo_last ? mexp_pkg::ST_FINISH
                                                : mexp_pkg::ST_SQ_WAIT;
                end
            end
            mexp_pkg::ST_SQ_WAIT:
            begin
                if (stat.unit_done)
                begin
                    state_next = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.start      = 1'b0;
        cmd.op         = mexp_pkg::OP_REDUCE;
        cmd.shift_expo = 1'b0;
        cmd.write_out  = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            mexp_pkg::ST_CHECK:
            begin
                cmd.start = !(stat.mod_zero || stat.expo_zero);
                cmd.op    = mexp_pkg::OP_REDUCE;
            end
            mexp_pkg::ST_BIT:
            begin
                // nonzero exponent with clear low bit always needs a square
                cmd.start      = 1'b1;
                cmd.op         = stat.expo_bit0 ? mexp_pkg::OP_MUL_ACC
                                                : mexp_pkg::OP_SQUARE;
                cmd.shift_expo = !stat.expo_bit0;
            end
            mexp_pkg::ST_MUL_WAIT:
            begin
                cmd.start      = stat.unit_done && !stat.expo_last;
                cmd.op         = mexp_pkg::OP_SQUARE;
                cmd.shift_expo = stat.unit_done && !stat.expo_last;
            end
            mexp_pkg::ST_FINISH:
            begin
                cmd.write_out = stat.out_free;
            end
            mexp_pkg::ST_REDUCE_WAIT,
            mexp_pkg::ST_SQ_WAIT:
            begin
                cmd.start = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/modular_exponentiation_top.sv
// Flow: load and reduce the base, then per exponent bit a square, plus a multiply
// first when the bit is set (the top bit takes only its multiply). One word in
// flight; the shared bit-serial multiply-reduce unit sets the rate.
// Output word is registered, so the next word is taken while it waits.
// rst_n clears the sequencer, unit control and output valid asynchronously.
module modular_exponentiation_top #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OPERAND_WIDTH-1:0] base_value,
    input  logic [OPERAND_WIDTH-1:0] exponent_value,
    input  logic [OPERAND_WIDTH-1:0] modulus_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OPERAND_WIDTH-1:0] power_result,
    output logic                     zero_modulus_error
);

    mexp_pkg::mexp_cmd_t    cmd;
    mexp_pkg::mexp_status_t stat;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mexp_datapath #(
        .W (OPERAND_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .base_value         (base_value),
        .exponent_value     (exponent_value),
        .modulus_value      (modulus_value),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .power_result       (power_result),
        .zero_modulus_error (zero_modulus_error)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_modulus_error |-> power_result == '0)
        else $error("zero modulus word carries nonzero result");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while one is in flight");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.unit_busy)
        else $error("multiply-reduce unit started while busy");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_out |-> !cmd.start && !stat.unit_busy)
        else $error("result written while a product is still running");

endmodule

### bench/modular_exponentiation_top_tb.sv
// Testbench for modular_exponentiation_top: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module modular_exponentiation_top_tb;

    localparam int W = mexp_pkg::OPERAND_WIDTH_DEFAULT;
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
    localparam logic [W-1:0] ALT_LOW = W'(ALL_ONES / 3);
    localparam logic [W-1:0] ALT_HIGH = ALL_ONES ^ ALT_LOW;
    localparam int MAX_GAP = 18;
    localparam int HOLD_CYCLES = 4000;
    localparam int DRAIN_CYCLES = 2200;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [W-1:0] power;
        logic         err;
    } power_word_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent_value;
    logic [W-1:0] modulus_value;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] power_result;
    logic         zero_modulus_error;

    power_word_t  pending_powers[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           send_burst = 0;
    int           recv_burst = 0;
    bit           hold_output = 1'b0;

    modular_exponentiation_top #(
        .OPERAND_WIDTH(W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .base_value(base_value),
        .exponent_value(exponent_value),
        .modulus_value(modulus_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .power_result(power_result),
        .zero_modulus_error(zero_modulus_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic power_word_t predict_power(input logic [W-1:0] b, input logic [W-1:0] e,
                                                  input logic [W-1:0] m);
        power_word_t r;
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] ex;
        r.power = '0;
        r.err = 1'b0;
        if (m == '0)
        begin
            r.err = 1'b1;
        end
        else
        begin
            acc = 64'd1;
            sq = {33'd0, b};
            ex = {33'd0, e};
            while (ex != 64'd0)
            begin
                if (ex[0])
                    acc = (acc * sq) % m;
                ex = ex >> 1;
                sq = (sq * sq) % m;
            end
            r.power = acc[W-1:0];
        end
        return r;
    endfunction

    // gap per word, with runs of back-to-back words
    function automatic int draw_gap(inout int burst);
        int g;
        if (burst > 0)
        begin
            burst--;
            g = 0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(4, 15);
            g = 0;
        end
        else
        begin
            g = $urandom_range(0, MAX_GAP);
        end
        return g;
    endfunction

    function automatic logic [W-1:0] rand_operand(input int nbits);
        logic [31:0] v;
        v = $urandom;
        if (nbits < 32)
            v = v & ((32'd1 << nbits) - 32'd1);
        return v[W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // entered and left at a rising edge; valid is held high across zero gaps
    task automatic send_word(input logic [W-1:0] b, input logic [W-1:0] e,
                             input logic [W-1:0] m);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base_value <= b;
        exponent_value <= e;
        modulus_value <= m;
        do
            @(posedge clk);
        while (!in_ready);
        pending_powers.push_back(predict_power(b, e, m));
    endtask

    task automatic test_directed_cases;
        send_word(W'(5), W'(0), W'(0));
        send_word(ALL_ONES, ALL_ONES, W'(0));
        send_word(W'(0), W'(0), W'(1));
        send_word(W'(7), W'(1), W'(1));
        send_word(ALL_ONES, ALL_ONES, W'(1));
        send_word(W'(0), W'(0), W'(13));
        send_word(W'(0), W'(9), W'(13));
        send_word(W'(3), W'(1), W'(7));
        send_word(W'(100), W'(3), W'(7));
        send_word(W'(13), W'(5), W'(13));
        send_word(W'(3), ALL_ONES, W'(2));
        send_word(W'(4), W'(10), W'(2));
        send_word(ALL_ONES, ALL_ONES, ALL_ONES);
        send_word(W'(ALL_ONES - 1), ALL_ONES, ALL_ONES);
        send_word(W'(ALL_ONES - 1), W'(2), ALL_ONES);
        send_word(ALT_LOW, ALT_HIGH, ALT_HIGH);
        send_word(ALT_HIGH, ALT_LOW, ALT_LOW);
        send_word(W'(2), W'(30), ALL_ONES);
        send_word(W'(0), ALL_ONES, ALL_ONES);
        send_word(W'(1), ALL_ONES, W'(1000003));
    endtask

    // mostly short exponents to keep the run short, odd moduli of zero and one
    task automatic test_random_mixed(input int count);
        logic [W-1:0] b;
        logic [W-1:0] e;
        logic [W-1:0] m;
        int sel;
        repeat (count)
        begin
            b = rand_operand($urandom_range(1, W));
            if ($urandom_range(0, 4) == 0)
                e = rand_operand(W);
            else
                e = rand_operand($urandom_range(0, 8));
            sel = $urandom_range(0, 15);
            if (sel == 0)
                m = '0;
            else if (sel == 1)
                m = W'(1);
            else
                m = rand_operand($urandom_range(1, W));
            send_word(b, e, m);
        end
    endtask

    task automatic test_full_width(input int count);
        repeat (count)
            send_word(rand_operand(W), rand_operand(W), rand_operand(W));
    endtask

    // receiver holds off while words keep coming, so the input must stall
    task automatic test_output_hold(input int count);
        hold_output = 1'b1;
        repeat (count)
            send_word(rand_operand(W), rand_operand($urandom_range(1, 6)),
                      rand_operand($urandom_range(1, W)));
    endtask

    always @(posedge clk)
    begin
        power_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("mismatch %0t: word with nothing expected, power %0d error %0b",
                         $realtime, power_result, zero_modulus_error);
                mismatch_count++;
            end
            else
            begin
                want = pending_powers.pop_front();
                if (power_result !== want.power)
                    report_mismatch("power_result", power_result, want.power);
                if (zero_modulus_error !== want.err)
                    report_mismatch("zero_modulus_error", W'(zero_modulus_error), W'(want.err));
            end
        end
    end

    initial
    begin : output_side
        int wait_cycles;
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                wait_cycles = draw_gap(recv_burst);
                if (wait_cycles > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        base_value <= '0;
        exponent_value <= '0;
        modulus_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_mixed(150);
        test_output_hold(30);
        test_full_width(60);
        test_random_mixed(30);
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/mexp_datapath.sv
src/mexp_ctrl.sv
src/modular_exponentiation_top.sv
bench/modular_exponentiation_top_tb.sv
